// ===== src/fgpc_pkg.sv =====
// ============================================================================
// fgpc_pkg: shared constants and helpers for the free gap placement checker
// Sizes of the obstacle bitmap and the gap max tree, plus bit-scan helpers.
// ============================================================================
package fgpc_pkg;

    localparam int POSITIONS = 1024;
    localparam int CELL_W    = $clog2(POSITIONS);
    localparam int GAP_W     = 10;

    // obstacle bitmap is stored as words, with a one-bit summary per word
    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int NWORDS    = POSITIONS / WORD_W;
    localparam int WA        = $clog2(NWORDS);

    // max tree: node 1 is the root, leaves at POSITIONS + cell
    localparam int TREE_D    = 2 * POSITIONS;
    localparam int TREE_AW   = $clog2(TREE_D);
    localparam int PR_W      = TREE_AW + 1;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    function automatic logic [BIT_W-1:0] msb_word(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) idx = BIT_W'(i);
        end
        return idx;
    endfunction

    function automatic logic [BIT_W-1:0] lsb_word(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) idx = BIT_W'(i);
        end
        return idx;
    endfunction

    function automatic logic [WA-1:0] msb_sum(input logic [NWORDS-1:0] v);
        logic [WA-1:0] idx;
        idx = '0;
        for (int i = 0; i < NWORDS; i++) begin
            if (v[i]) idx = WA'(i);
        end
        return idx;
    endfunction

    function automatic logic [WA-1:0] lsb_sum(input logic [NWORDS-1:0] v);
        logic [WA-1:0] idx;
        idx = '0;
        for (int i = NWORDS - 1; i >= 0; i--) begin
            if (v[i]) idx = WA'(i);
        end
        return idx;
    endfunction

endpackage

// ===== src/free_gap_placement_checker.sv =====
// ============================================================================
// free_gap_placement_checker: obstacle gap tracker with a max tree
// Inserts obstacles on a line of cells and answers block-fit queries.
// ============================================================================
// Usage: after reset the block runs a clearing pass over every tree node
// with busy high. A beat is taken when start is high and busy is low;
// busy then stays high until the item is finished. mode 0 inserts an obstacle
// at position and gives no result; mode 1 returns fits and largest_gap on
// o_valid for exactly one cycle. The receiver cannot stall: sample o_fits and
// o_largest_gap whenever o_valid is high. Timing is set by the single read
// port of the gap tree RAM, which every tree step goes through. A query first
// searches the bitmap for the nearest obstacle at or before position, then
// climbs the tree level by level through the left edge, right edge and climb
// steps, and closes with the result. An insert searches for the predecessor
// and successor, then makes one or two leaf-to-root updates that read each
// sibling and write each parent. An insert at an existing obstacle keeps busy
// high for 1 cycle. A new beat may be taken in the cycle o_valid is high.
// ============================================================================
module free_gap_placement_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_mode,
    input  logic [fgpc_pkg::CELL_W-1:0]  i_position,
    input  logic [fgpc_pkg::GAP_W-1:0]   i_block_size,
    output logic                         o_valid,
    output logic                         o_fits,
    output logic [fgpc_pkg::GAP_W-1:0]   o_largest_gap
);

    import fgpc_pkg::*;

    // one-hot sequencer states
    typedef enum logic [10:0] {
        S_CLR   = 11'b000_0000_0001, // clearing pass after reset
        S_IDLE  = 11'b000_0000_0010,
        S_WORD  = 11'b000_0000_0100, // bitmap word of the item's cell is back
        S_PREDW = 11'b000_0000_1000, // word holding the predecessor is back
        S_SUCCW = 11'b000_0001_0000, // word holding the successor is back
        S_DISP  = 11'b000_0010_0000, // start tree work
        S_TRD   = 11'b000_0100_0000, // tree update: read sibling
        S_TWR   = 11'b000_1000_0000, // tree update: write parent
        S_PML   = 11'b001_0000_0000, // prefix max: left edge
        S_PMR   = 11'b010_0000_0000, // prefix max: right edge
        S_PMS   = 11'b100_0000_0000  // prefix max: climb a level
    } t_state;

    localparam logic [WORD_W-1:0] WORD_ONES = '1;
    localparam logic [NWORDS-1:0] SUM_ONES  = '1;
    localparam logic [BIT_W-1:0]  TOP_BIT   = BIT_W'(WORD_W - 1);
    localparam logic [TREE_AW-1:0] ROOT     = TREE_AW'(1);

    t_state              r_state, n_state;
    logic [TREE_AW-1:0]  r_clr, n_clr;
    logic [NWORDS-1:0]   r_sum, n_sum;      // word holds any obstacle
    logic                r_mode, n_mode;
    logic [CELL_W-1:0]   r_x, n_x;
    logic [GAP_W-1:0]    r_sz, n_sz;
    logic [CELL_W-1:0]   r_p, n_p;          // nearest obstacle before / at x
    logic [CELL_W-1:0]   r_nx, n_nx;        // next obstacle after x
    logic [WA-1:0]       r_pw, n_pw;
    logic [WA-1:0]       r_nw, n_nw;
    logic                r_has_next, n_has_next;
    logic                r_need_nw, n_need_nw;
    logic                r_second, n_second;
    logic [TREE_AW-1:0]  r_k, n_k;          // node being climbed from
    logic [GAP_W-1:0]    r_cur, n_cur;      // max carried up the tree
    logic [PR_W-1:0]     r_l, n_l;
    logic [PR_W-1:0]     r_r, n_r;
    logic [GAP_W-1:0]    r_m, n_m;
    logic                r_pend, n_pend;
    logic                r_valid, n_valid;
    logic                r_fits, n_fits;
    logic [GAP_W-1:0]    r_gap, n_gap;

    // RAM ports
    logic                bm_we;
    logic [WA-1:0]       bm_waddr, bm_raddr;
    logic [WORD_W-1:0]   bm_wdata, bm_rdata;
    logic                tr_we;
    logic [TREE_AW-1:0]  tr_waddr, tr_raddr;
    logic [GAP_W-1:0]    tr_wdata, tr_rdata;

    // search helpers
    logic [WA-1:0]       wx;
    logic [BIT_W-1:0]    bx;
    logic [WORD_W-1:0]   le_mask, bit_x, lo_bits, hi_bits;
    logic [NWORDS-1:0]   sum_lt, sum_gt;
    logic [GAP_W-1:0]    tail, best, sib_max;

    assign wx      = r_x[CELL_W-1:BIT_W];
    assign bx      = r_x[BIT_W-1:0];
    assign le_mask = WORD_ONES >> (TOP_BIT - bx);
    assign bit_x   = WORD_W'(1) << bx;
    assign lo_bits = bm_rdata & le_mask;
    assign hi_bits = bm_rdata & ~le_mask;
    assign sum_lt  = r_sum & ~(SUM_ONES << wx);
    assign sum_gt  = r_sum & ((SUM_ONES << wx) << 1);
    assign tail    = GAP_W'(r_x - r_p);
    assign best    = (r_m > tail) ? r_m : tail;
    assign sib_max = (tr_rdata > r_cur) ? tr_rdata : r_cur;

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_sum      = r_sum;
        n_mode     = r_mode;
        n_x        = r_x;
        n_sz       = r_sz;
        n_p        = r_p;
        n_nx       = r_nx;
        n_pw       = r_pw;
        n_nw       = r_nw;
        n_has_next = r_has_next;
        n_need_nw  = r_need_nw;
        n_second   = r_second;
        n_k        = r_k;
        n_cur      = r_cur;
        n_l        = r_l;
        n_r        = r_r;
        n_m        = r_m;
        n_pend     = r_pend;
        n_valid    = 1'b0;
        n_fits     = r_fits;
        n_gap      = r_gap;

        bm_we      = 1'b0;
        bm_waddr   = wx;
        bm_wdata   = bm_rdata | bit_x;
        bm_raddr   = wx;
        tr_we      = 1'b0;
        tr_waddr   = r_k;
        tr_wdata   = r_cur;
        tr_raddr   = r_k ^ ROOT;

        case (r_state)
            S_CLR: begin
                tr_we    = 1'b1;
                tr_waddr = r_clr;
                tr_wdata = '0;
                // bitmap is shallower: only the low addresses of the sweep
                bm_we    = (r_clr < TREE_AW'(NWORDS));
                bm_waddr = r_clr[WA-1:0];
                bm_wdata = (r_clr == '0) ? WORD_W'(1) : '0;
                n_clr    = r_clr + TREE_AW'(1);
                if (r_clr == {TREE_AW{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                bm_raddr = i_position[CELL_W-1:BIT_W];
                if (start) begin
                    n_mode   = i_mode;
                    n_x      = i_position;
                    n_sz     = i_block_size;
                    n_second = 1'b0;
                    n_state  = S_WORD;
                end
            end
            S_WORD: begin
                if (r_mode == MODE_INSERT && bm_rdata[bx]) begin
                    n_state = S_IDLE; // already an obstacle
                end else begin
                    // predecessor: same word if any bit at or below, else summary
                    n_p  = {wx, msb_word(lo_bits)};
                    n_pw = msb_sum(sum_lt);
                    // successor, used by inserts only
                    n_nx       = {wx, lsb_word(hi_bits)};
                    n_nw       = lsb_sum(sum_gt);
                    n_has_next = (hi_bits != '0) || (sum_gt != '0);
                    n_need_nw  = (hi_bits == '0) && (sum_gt != '0);
                    if (r_mode == MODE_INSERT) begin
                        bm_we = 1'b1;
                        n_sum = r_sum | (NWORDS'(1) << wx);
                    end
                    if (lo_bits == '0) begin
                        bm_raddr = n_pw;
                        n_state  = S_PREDW;
                    end else if (r_mode == MODE_INSERT && n_need_nw) begin
                        bm_raddr = n_nw;
                        n_state  = S_SUCCW;
                    end else begin
                        n_state = S_DISP;
                    end
                end
            end
            S_PREDW: begin
                n_p = {r_pw, msb_word(bm_rdata)};
                if (r_mode == MODE_INSERT && r_need_nw) begin
                    bm_raddr = r_nw;
                    n_state  = S_SUCCW;
                end else begin
                    n_state = S_DISP;
                end
            end
            S_SUCCW: begin
                n_nx    = {r_nw, lsb_word(bm_rdata)};
                n_state = S_DISP;
            end
            S_DISP: begin
                if (r_mode == MODE_INSERT) begin
                    // leaf of the new obstacle gets its gap to the predecessor
                    tr_we    = 1'b1;
                    tr_waddr = {1'b1, r_x};
                    tr_wdata = GAP_W'(r_x - r_p);
                    n_k      = {1'b1, r_x};
                    n_cur    = GAP_W'(r_x - r_p);
                    n_state  = S_TRD;
                end else begin
                    n_l     = PR_W'(POSITIONS);
                    n_r     = PR_W'(POSITIONS) + PR_W'(r_p) + PR_W'(1);
                    n_m     = '0;
                    n_pend  = 1'b0;
                    n_state = S_PML;
                end
            end
            S_TRD: begin
                if (r_k == ROOT) begin
                    if (!r_second && r_has_next) begin
                        // next obstacle's gap now ends at the new one
                        tr_we    = 1'b1;
                        tr_waddr = {1'b1, r_nx};
                        tr_wdata = GAP_W'(r_nx - r_x);
                        n_k      = {1'b1, r_nx};
                        n_cur    = GAP_W'(r_nx - r_x);
                        n_second = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    tr_raddr = r_k ^ ROOT;
                    n_state  = S_TWR;
                end
            end
            S_TWR: begin
                tr_we    = 1'b1;
                tr_waddr = r_k >> 1;
                tr_wdata = sib_max;
                n_cur    = sib_max;
                n_k      = r_k >> 1;
                n_state  = S_TRD;
            end
            S_PML: begin
                if (r_l < r_r) begin
                    tr_raddr = r_l[TREE_AW-1:0];
                    n_pend   = r_l[0];
                    if (r_l[0]) begin
                        n_l = r_l + PR_W'(1);
                    end
                    n_state = S_PMR;
                end else begin
                    n_valid = 1'b1;
                    n_gap   = best;
                    n_fits  = (best >= r_sz);
                    n_state = S_IDLE;
                end
            end
            S_PMR: begin
                if (r_pend && tr_rdata > r_m) begin
                    n_m = tr_rdata;
                end
                tr_raddr = r_r[TREE_AW-1:0] - TREE_AW'(1);
                n_pend   = r_r[0];
                if (r_r[0]) begin
                    n_r = r_r - PR_W'(1);
                end
                n_state = S_PMS;
            end
            S_PMS: begin
                if (r_pend && tr_rdata > r_m) begin
                    n_m = tr_rdata;
                end
                n_pend  = 1'b0;
                n_l     = r_l >> 1;
                n_r     = r_r >> 1;
                n_state = S_PML;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_sum   <= NWORDS'(1);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_sum   <= n_sum;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_x        <= n_x;
        r_sz       <= n_sz;
        r_p        <= n_p;
        r_nx       <= n_nx;
        r_pw       <= n_pw;
        r_nw       <= n_nw;
        r_has_next <= n_has_next;
        r_need_nw  <= n_need_nw;
        r_second   <= n_second;
        r_k        <= n_k;
        r_cur      <= n_cur;
        r_l        <= n_l;
        r_r        <= n_r;
        r_m        <= n_m;
        r_pend     <= n_pend;
        r_fits     <= n_fits;
        r_gap      <= n_gap;
    end

    fgpc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    fgpc_ram #(
        .WIDTH (GAP_W),
        .DEPTH (TREE_D)
    ) u_tree (
        .i_clk   (i_clk),
        .i_we    (tr_we),
        .i_waddr (tr_waddr),
        .i_wdata (tr_wdata),
        .i_raddr (tr_raddr),
        .o_rdata (tr_rdata)
    );

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_fits        = r_fits;
    assign o_largest_gap = r_gap;

`ifndef SYNTHESIS
    // a result beat never repeats in the next cycle
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held two cycles");

    // cell 0 always holds an obstacle, so its word is never empty
    a_word0_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum[0])
        else $error("summary lost word 0");

    // tree walks never write the unused node 0 outside the clearing pass
    a_no_node0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tr_we && r_state != S_CLR) |-> (tr_waddr != '0))
        else $error("tree write to node 0");

    // a parent write always climbs from below the root
    a_climb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TWR) |-> (r_k > ROOT))
        else $error("tree climb past root");

    // accepting an item never yields a result in the next cycle
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !r_valid)
        else $error("result too early");
`endif

endmodule

// ===== src/fgpc_ram.sv =====
// ============================================================================
// fgpc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module fgpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
